### sv/lattice_coeff_compress_pack_unit_macros.svh
// Assertion macros shared by the lattice coefficient compress/pack block.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef LATTICE_COEFF_COMPRESS_PACK_UNIT_MACROS_SVH
`define LATTICE_COEFF_COMPRESS_PACK_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LCCP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define LCCP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/lccp_pkg.sv
// Package for the lattice coefficient compress/pack block.
// Holds widths, the modulus constants, the queue entry type and helpers.
`default_nettype none

package lccp_pkg;

   localparam int LCCP_COEF_W       = 13;
   localparam int LCCP_VALUE_W      = 12;
   localparam int LCCP_WIDTH_W      = 4;
   localparam int LCCP_NUM_W        = 24;
   localparam int LCCP_RECIP_W      = 22;
   localparam int LCCP_PROD_W       = LCCP_NUM_W + LCCP_RECIP_W;
   localparam int LCCP_RECIP_SHIFT  = 33;
   localparam int LCCP_ACC_W        = LCCP_VALUE_W + 7;
   localparam int LCCP_QUEUE_DEPTH  = 4;

   localparam logic [LCCP_VALUE_W-1:0] LCCP_Q      = 12'd3329;
   localparam logic [LCCP_VALUE_W-1:0] LCCP_HALF_Q = 12'd1664;
   localparam logic [LCCP_RECIP_W-1:0] LCCP_RECIP  = 22'd2580335;
   localparam logic [LCCP_WIDTH_W-1:0] LCCP_FULL_WIDTH = 4'd12;
   localparam logic [LCCP_WIDTH_W-1:0] LCCP_MIN_WIDTH  = 4'd1;

   // One coefficient after compression, on its way to the packer
   typedef struct packed {
      logic [LCCP_VALUE_W-1:0] value;
      logic                    last;
   } lccp_entry_type;

   // Clamp the raw width register to the supported range
   function automatic logic [LCCP_WIDTH_W-1:0] lccp_eff_width(
      input logic [LCCP_WIDTH_W-1:0] raw
   );
      logic [LCCP_WIDTH_W-1:0] w;
      w = raw;
      if (raw == '0) begin
         w = LCCP_MIN_WIDTH;
      end else if (raw > LCCP_FULL_WIDTH) begin
         w = LCCP_FULL_WIDTH;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

### sv/lccp_req_if.sv
// Input channel: one signed coefficient and its end-of-polynomial flag.
// Depends on lccp_pkg for field widths.
`default_nettype none

interface lccp_req_if import lccp_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [LCCP_COEF_W-1:0] coefficient;
   logic                          last_coefficient;

   modport source (output valid, output coefficient, output last_coefficient, input ready);
   modport sink   (input valid, input coefficient, input last_coefficient, output ready);
endinterface

`default_nettype wire

### sv/lccp_rsp_if.sv
// Result channel: one packed byte and its end-of-polynomial flag.
// Standalone, no package needed.
`default_nettype none

interface lccp_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### sv/lccp_front.sv
// Front end: accepts coefficients, reduces them mod q and compresses them.
// Two register stages; feeds lccp_queue. Depends on lccp_pkg, lccp_req_if.
`default_nettype none

module lccp_front import lccp_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   lccp_req_if.sink                     req_chan,
   input  wire logic [LCCP_WIDTH_W-1:0] eff_width,
   input  wire logic                    queue_full,
   output logic                         queue_push,
   output lccp_entry_type               queue_data
);

   logic                      s1_valid_ff, s1_valid_in;
   logic [LCCP_VALUE_W-1:0]   s1_x_ff, s1_x_in;
   logic                      s1_last_ff, s1_last_in;
   logic                      s2_valid_ff, s2_valid_in;
   logic [LCCP_VALUE_W-1:0]   s2_x_ff, s2_x_in;
   logic [LCCP_VALUE_W-1:0]   s2_quo_ff, s2_quo_in;
   logic                      s2_last_ff, s2_last_in;

   logic                      s2_free, s1_move, s1_free, take;
   logic signed [LCCP_COEF_W:0] c_ext, c_add, c_add2, c_sub, q_s;
   logic [LCCP_COEF_W:0]      x_red;
   logic [LCCP_NUM_W-1:0]     num;
   logic [LCCP_PROD_W-1:0]    prod;
   logic [LCCP_VALUE_W-1:0]   value_mask;

   // Stage handshake: each stage moves when the one after it has room
   assign queue_push     = s2_valid_ff && !queue_full;
   assign s2_free        = !s2_valid_ff || !queue_full;
   assign s1_move        = s1_valid_ff && s2_free;
   assign s1_free        = !s1_valid_ff || s2_free;
   assign req_chan.ready = s1_free;
   assign take           = req_chan.valid && s1_free;

   // Reduce the signed coefficient into [0, q)
   always_comb begin
      q_s    = $signed({2'b00, LCCP_Q});
      c_ext  = $signed({req_chan.coefficient[LCCP_COEF_W-1], req_chan.coefficient});
      c_add  = c_ext + q_s;
      c_add2 = c_add + q_s;
      c_sub  = c_ext - q_s;
      if (c_ext < 0) begin
         x_red = (c_add < 0) ? c_add2 : c_add;
      end else begin
         x_red = (c_ext >= q_s) ? c_sub : c_ext;
      end
   end

   // Compress: round(2^d * x / q) through a constant reciprocal multiply
   always_comb begin
      num  = (LCCP_NUM_W'(s1_x_ff) << eff_width) + LCCP_NUM_W'(LCCP_HALF_Q);
      prod = LCCP_PROD_W'(num) * LCCP_PROD_W'(LCCP_RECIP);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_x_in     = s1_x_ff;
      s1_last_in  = s1_last_ff;
      if (take) begin
         s1_valid_in = 1'b1;
         s1_x_in     = x_red[LCCP_VALUE_W-1:0];
         s1_last_in  = req_chan.last_coefficient;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      s2_x_in     = s2_x_ff;
      s2_quo_in   = s2_quo_ff;
      s2_last_in  = s2_last_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
         s2_x_in     = s1_x_ff;
         s2_quo_in   = prod[LCCP_RECIP_SHIFT+LCCP_VALUE_W-1:LCCP_RECIP_SHIFT];
         s2_last_in  = s1_last_ff;
      end else if (queue_push) begin
         s2_valid_in = 1'b0;
      end
   end

   // Pick plain pack or compressed value, masked to d bits
   always_comb begin
      value_mask       = ~({LCCP_VALUE_W{1'b1}} << eff_width);
      queue_data.last  = s2_last_ff;
      if (eff_width == LCCP_FULL_WIDTH) begin
         queue_data.value = s2_x_ff;
      end else begin
         queue_data.value = s2_quo_ff & value_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_x_ff    <= s1_x_in;
      s1_last_ff <= s1_last_in;
      s2_x_ff    <= s2_x_in;
      s2_quo_ff  <= s2_quo_in;
      s2_last_ff <= s2_last_in;
   end

endmodule

`default_nettype wire

### sv/lccp_queue.sv
// Small FIFO between the compressor front end and the byte packer.
// Depends on lccp_pkg for the entry type.
`default_nettype none

`include "lattice_coeff_compress_pack_unit_macros.svh"

module lccp_queue import lccp_pkg::*; #(
   parameter int DEPTH = LCCP_QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire lccp_entry_type push_data,
   output logic          full,
   input  wire logic     pop,
   output lccp_entry_type pop_data,
   output logic          empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lccp_entry_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `LCCP_ASSERT_NOW(a_queue_no_overflow, push, !full, "push into full queue")
   `LCCP_ASSERT_NOW(a_queue_no_underflow, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

### sv/lccp_back.sv
// Back end: appends d-bit values to the bit accumulator, emits bytes one per
// cycle when not stalled, via an output register. Needs lccp_pkg, lccp_rsp_if.
`default_nettype none

`include "lattice_coeff_compress_pack_unit_macros.svh"

module lccp_back import lccp_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [LCCP_WIDTH_W-1:0] eff_width,
   input  wire logic                    queue_empty,
   input  wire lccp_entry_type          queue_data,
   output logic                         queue_pop,
   lccp_rsp_if.source                   rsp_chan
);

   logic [6:0]            pend_bits_ff, pend_bits_in;
   logic [2:0]            pend_cnt_ff, pend_cnt_in;
   logic [15:0]           wb_data_ff, wb_data_in;
   logic [1:0]            wb_cnt_ff, wb_cnt_in;
   logic                  wb_last_ff, wb_last_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  out_last_ff, out_last_in;

   logic [LCCP_ACC_W-1:0] acc, acc_rest;
   logic [4:0]            total;
   logic [1:0]            n_bytes;
   logic                  out_free, move, wb_done;

   // Merge the new value above the pending bits
   always_comb begin
      acc   = LCCP_ACC_W'(pend_bits_ff) | (LCCP_ACC_W'(queue_data.value) << pend_cnt_ff);
      total = 5'(pend_cnt_ff) + 5'(eff_width);
      if (queue_data.last) begin
         n_bytes = (total > 5'd8) ? 2'd2 : 2'd1;
      end else if (total >= 5'd16) begin
         n_bytes = 2'd2;
      end else if (total >= 5'd8) begin
         n_bytes = 2'd1;
      end else begin
         n_bytes = 2'd0;
      end
      acc_rest = acc >> {n_bytes, 3'b000};
   end

   // Byte buffer drains into the output register; refill when it empties
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign move      = (wb_cnt_ff != 2'd0) && out_free;
   assign wb_done   = (wb_cnt_ff == 2'd0) || ((wb_cnt_ff == 2'd1) && move);
   assign queue_pop = !queue_empty && wb_done;

   always_comb begin
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      wb_data_in   = wb_data_ff;
      wb_cnt_in    = wb_cnt_ff;
      wb_last_in   = wb_last_ff;
      if (queue_pop) begin
         wb_data_in = acc[15:0];
         wb_cnt_in  = n_bytes;
         wb_last_in = queue_data.last;
         if (queue_data.last) begin
            pend_bits_in = '0;
            pend_cnt_in  = '0;
         end else begin
            pend_bits_in = acc_rest[6:0];
            pend_cnt_in  = total[2:0];
         end
      end else if (move) begin
         wb_data_in = {8'h00, wb_data_ff[15:8]};
         wb_cnt_in  = wb_cnt_ff - 2'd1;
      end
   end

   // Output register: load a byte, or drop valid once it transfers
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_byte_in  = wb_data_ff[7:0];
         out_last_in  = wb_last_ff && (wb_cnt_ff == 2'd1);
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_byte  = out_byte_ff;
   assign rsp_chan.last_byte = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         wb_cnt_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         wb_cnt_ff    <= wb_cnt_in;
         out_valid_ff <= out_valid_in;
      end
      wb_data_ff  <= wb_data_in;
      wb_last_ff  <= wb_last_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   `LCCP_ASSERT_NEXT(a_last_clears_pending, queue_pop && queue_data.last, (pend_cnt_ff == 3'd0) && (pend_bits_ff == 7'd0), "accumulator not cleared after last coefficient")
   `LCCP_ASSERT_NEXT(a_stalled_bytes_kept, (wb_cnt_ff != 2'd0) && !out_free, wb_cnt_ff == $past(wb_cnt_ff), "buffered bytes lost during stall")

endmodule

`default_nettype wire

### sv/lattice_coeff_compress_pack_unit.sv
// Lattice polynomial coefficient compressor and byte packer, encode direction.
// req_chan takes one signed 13-bit coefficient, q = 3329, plus a flag for
// the final coefficient. rsp_chan gives packed bytes, bits filled LSB first,
// with last_byte on the final byte of a polynomial. At the final coefficient
// at most two bytes go out, the last zero-padded; bits past them are dropped.
// csr_write_data sets d, the bits per coefficient (1..12, 12 = plain pack);
// it resets to 12. The user must write it only while the block is idle;
// the block itself does not enforce this. The first byte of a coefficient
// reaches rsp_chan through the reduce stage, multiply stage, queue, byte
// buffer and output register, in that order.
// Throughput: a coefficient enters every cycle while the queue has room; the
// packer pops the next coefficient as the last byte of the one before moves
// into the byte-wide output register, so two-byte coefficients slow it down.
// When rsp_chan stalls the output register holds its byte, the four-entry queue
// fills and req_chan.ready drops; nothing is lost.
// Reset clears the accumulator, all valid state and sets d to 12.
`default_nettype none

module lattice_coeff_compress_pack_unit import lccp_pkg::*; #(
   parameter int QUEUE_DEPTH = LCCP_QUEUE_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   lccp_req_if.sink                     req_chan,
   lccp_rsp_if.source                   rsp_chan,
   input  wire logic                    csr_write_enable,
   input  wire logic [LCCP_WIDTH_W-1:0] csr_write_data
);

   logic [LCCP_WIDTH_W-1:0] csr_bit_width_ff, csr_bit_width_in;
   logic [LCCP_WIDTH_W-1:0] eff_width;
   logic                    queue_push, queue_full, queue_pop, queue_empty;
   lccp_entry_type          push_data, pop_data;

   // Width register
   always_comb begin
      csr_bit_width_in = csr_write_enable ? csr_write_data : csr_bit_width_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_bit_width_ff <= LCCP_FULL_WIDTH;
      end else begin
         csr_bit_width_ff <= csr_bit_width_in;
      end
   end

   assign eff_width = lccp_eff_width(csr_bit_width_ff);

   lccp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .eff_width  (eff_width),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (push_data)
   );

   lccp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   lccp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .eff_width   (eff_width),
      .queue_empty (queue_empty),
      .queue_data  (pop_data),
      .queue_pop   (queue_pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

### dv/lccp_pack_ledger_pkg.sv
// Expected-byte ledger for the lattice coefficient compress/pack testbench.
// Predicts the packed byte stream per coefficient; depends on lccp_pkg widths.
package lccp_pack_ledger_pkg;
   import lccp_pkg::*;

   localparam int              MODULUS      = 3329;
   localparam longint unsigned HALF_MODULUS = 1664;
   localparam longint unsigned RECIPROCAL   = 2580335;
   localparam int              RECIP_SHIFT  = 33;
   localparam int unsigned     PLAIN_WIDTH  = 12;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } packed_byte_type;

   class packed_byte_ledger;
      int unsigned             mismatch_count;
      logic [LCCP_WIDTH_W-1:0] width_reg;
      longint unsigned         pending_bits;
      int unsigned             pending_count;
      packed_byte_type         expected_bytes[$];

      function new();
         mismatch_count = 0;
         width_reg      = 4'd12;
         pending_bits   = 0;
         pending_count  = 0;
      endfunction

      // Print one line per mismatch and count it
      task report_mismatch(string msg);
         $display("%0t lccp mismatch: %s", $realtime, msg);
         mismatch_count++;
      endtask

      function void set_width(logic [LCCP_WIDTH_W-1:0] raw);
         width_reg = raw;
      endfunction

      function int unsigned bytes_owed();
         return expected_bytes.size();
      endfunction

      // Reduce, compress and pack one transferred coefficient
      function void note_coefficient(logic signed [LCCP_COEF_W-1:0] coefficient,
                                     logic last_coefficient);
         int unsigned     d;
         int unsigned     total;
         int unsigned     n;
         int              c;
         longint unsigned x;
         longint unsigned v;
         longint unsigned acc;
         packed_byte_type made[2];
         d = width_reg;
         if (d == 0) begin
            d = 1;
         end else if (d > PLAIN_WIDTH) begin
            d = PLAIN_WIDTH;
         end
         // bring any 13-bit value into [0, q)
         c = coefficient;
         if (c < 0) begin
            c += MODULUS;
         end
         if (c < 0) begin
            c += MODULUS;
         end else if (c >= MODULUS) begin
            c -= MODULUS;
         end
         x = longint'(c);
         if (d == PLAIN_WIDTH) begin
            v = x;
         end else begin
            v = ((((x << d) + HALF_MODULUS) * RECIPROCAL) >> RECIP_SHIFT) &
                ((64'd1 << d) - 1);
         end
         acc   = pending_bits | (v << pending_count);
         total = pending_count + d;
         n     = 0;
         // emit whole bytes, at most two per coefficient
         while (total >= 8 && n < 2) begin
            made[n] = '{data: acc[7:0], last: 1'b0};
            acc     = acc >> 8;
            total  -= 8;
            n++;
         end
         if (last_coefficient) begin
            // flush the zero-padded tail unless two bytes already went out
            if (total > 0 && n < 2) begin
               made[n] = '{data: acc[7:0] & 8'((64'd1 << total) - 1), last: 1'b0};
               n++;
            end
            made[n-1].last = 1'b1;
            pending_bits   = 0;
            pending_count  = 0;
         end else begin
            pending_count = total & 7;
            pending_bits  = acc & ((64'd1 << pending_count) - 1);
         end
         for (int i = 0; i < int'(n); i++) begin
            expected_bytes.push_back(made[i]);
         end
      endfunction

      // Compare one transferred byte against the oldest prediction
      task check_byte(logic [7:0] out_byte, logic last_byte);
         packed_byte_type want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte 0x%02h last_byte %0b",
                                      out_byte, last_byte));
            return;
         end
         want = expected_bytes.pop_front();
         if (out_byte !== want.data) begin
            report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h",
                                      out_byte, want.data));
         end
         if (last_byte !== want.last) begin
            report_mismatch($sformatf("last_byte %0b, want %0b on byte 0x%02h",
                                      last_byte, want.last, want.data));
         end
      endtask

      task close_out();
         if (expected_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
         end
      endtask
   endclass

endpackage

### dv/lattice_coeff_compress_pack_unit_test.sv
// Top of the compress/pack testbench: clock, reset, stimulus and byte checking.
// Depends on lccp_pkg, lccp_req_if, lccp_rsp_if, lccp_pack_ledger_pkg and the RTL.
module lattice_coeff_compress_pack_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lccp_pkg::*;
   import lccp_pack_ledger_pkg::*;

   localparam int unsigned ITEM_TARGET   = 1700;
   localparam int unsigned SETTLE_CYCLES = 12;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [LCCP_WIDTH_W-1:0] csr_write_data;
   bit                      steady;
   int unsigned             items_sent;

   lccp_req_if req_chan ();
   lccp_rsp_if rsp_chan ();

   packed_byte_ledger ledger = new();

   lattice_coeff_compress_pack_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, a few long ones, none in steady stretches
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   function automatic logic signed [LCCP_COEF_W-1:0] random_coefficient();
      int r;
      int c;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         c = int'($urandom_range(0, 6656)) - 3328;
      end else if (r < 90) begin
         case ($urandom_range(0, 5))
            0: c = -3328;
            1: c = 3328;
            2: c = 0;
            3: c = -1;
            4: c = 1664;
            default: c = 1665;
         endcase
      end else begin
         // any 13-bit pattern, out-of-range values included
         c = int'($urandom_range(0, 8191));
      end
      return c[LCCP_COEF_W-1:0];
   endfunction

   // Present one coefficient after a gap and hold it until the transfer
   task automatic offer_coefficient(input logic signed [LCCP_COEF_W-1:0] coefficient,
                                    input logic last_coefficient,
                                    input int unsigned gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.coefficient      <= coefficient;
      req_chan.last_coefficient <= last_coefficient;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      ledger.note_coefficient(coefficient, last_coefficient);
      items_sent++;
   endtask

   // Drop valid, wait for every predicted byte, then let the pipeline empty
   task automatic settle_idle();
      req_chan.valid <= 1'b0;
      while (ledger.bytes_owed() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [LCCP_WIDTH_W-1:0] width);
      settle_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= width;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ledger.set_width(width);
   endtask

   // One width, a few polynomials; the final one may be cut short
   task automatic run_phase(input logic [LCCP_WIDTH_W-1:0] width);
      int unsigned budget;
      int unsigned poly_len;
      int unsigned r;
      bit          cut_short;
      write_width(width);
      steady = ($urandom_range(0, 3) == 0);
      budget = $urandom_range(30, 120);
      while (budget > 0) begin
         r = $urandom_range(0, 9);
         if (r == 0) begin
            poly_len = 256;
         end else if (r < 7) begin
            poly_len = $urandom_range(1, 16);
         end else begin
            poly_len = $urandom_range(17, 64);
         end
         cut_short = (poly_len >= budget) && ($urandom_range(0, 5) == 0);
         for (int unsigned i = 0; i < poly_len; i++) begin
            offer_coefficient(random_coefficient(),
                              (i == poly_len - 1) && !cut_short, pick_gap());
         end
         budget = (poly_len >= budget) ? 0 : budget - poly_len;
      end
      steady = 1'b0;
   endtask

   // Accept and check bytes; stall at random
   initial begin
      int unsigned stall_left;
      stall_left    = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            ledger.check_byte(rsp_chan.out_byte, rsp_chan.last_byte);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   initial begin
      int extreme_coefs[13] = '{-3328, 3328, 0, -1, 1, 1664, 1665, -1664,
                                3329, -3329, 4095, -4096, 2000};
      int rounding_coefs[5] = '{1664, 832, 833, -1, 3328};
      logic [LCCP_WIDTH_W-1:0] width;
      reset                     = 1'b1;
      steady                    = 1'b0;
      items_sent                = 0;
      req_chan.valid            = 1'b0;
      req_chan.coefficient      = '0;
      req_chan.last_coefficient = 1'b0;
      csr_write_enable          = 1'b0;
      csr_write_data            = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes and out-of-range values at the reset width (plain pack)
      foreach (extreme_coefs[i]) begin
         offer_coefficient(13'(extreme_coefs[i]), i == 12, pick_gap());
      end

      // rounding edges at one bit per coefficient
      write_width(4'd1);
      foreach (rounding_coefs[i]) begin
         offer_coefficient(13'(rounding_coefs[i]), i == 4, pick_gap());
      end

      // seven bits left pending, then a plain-pack last coefficient: the
      // tail past two bytes is dropped
      write_width(4'd7);
      offer_coefficient(13'sd3000, 1'b0, 0);
      write_width(4'd12);
      offer_coefficient(-13'sd5, 1'b1, 0);

      // sweep every width once, then random widths biased to the extremes
      width = '0;
      for (int k = 0; items_sent < ITEM_TARGET; k++) begin
         if (k < 16) begin
            width = 4'(k);
         end else if ($urandom_range(0, 9) < 2) begin
            width = 4'd12;
         end else if ($urandom_range(0, 9) == 0) begin
            width = 4'd1;
         end else begin
            width = 4'($urandom_range(0, 15));
         end
         run_phase(width);
      end

      settle_idle();
      ledger.close_out();
      if (ledger.mismatch_count == 0) begin
         $display("lattice_coeff_compress_pack_unit_test: done, clean");
      end else begin
         $display("lattice_coeff_compress_pack_unit_test: done, errors");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #20ms;
      $display("lattice_coeff_compress_pack_unit_test: done, errors");
      $finish;
   end

endmodule
